/* sv/icl_pkg.sv */
// Shared constants for the intercom code lock: screen modes, key codes, register map.
package icl_pkg;

   // Screen mode codes, also the state of the controller
   localparam logic [2:0] MODE_WELCOME = 3'd0;
   localparam logic [2:0] MODE_ENTRY   = 3'd1;
   localparam logic [2:0] MODE_RING    = 3'd2;
   localparam logic [2:0] MODE_OPENED  = 3'd3;
   localparam logic [2:0] MODE_INVALID = 3'd4;

   // Key codes
   localparam logic [7:0] KEY_0 = 8'h30;
   localparam logic [7:0] KEY_1 = 8'h31;
   localparam logic [7:0] KEY_8 = 8'h38;
   localparam logic [7:0] KEY_9 = 8'h39;
   localparam logic [7:0] KEY_C = 8'h43;

   // Item kinds
   localparam logic ACTION_KEY  = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // Register map
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCESS_CODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RING_TICKS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS  = 2'd2;

   localparam logic [11:0] ACCESS_CODE_RESET = 12'h123;
   localparam logic [7:0]  RING_TICKS_RESET  = 8'd15;
   localparam logic [7:0]  HOLD_TICKS_RESET  = 8'd5;

   typedef logic [2:0] screen_type;

endpackage

/* sv/icl_if.sv */
// Valid/ready channel interfaces for keypad/tick words and screen result words.
interface icl_req_if
   import icl_pkg::*;
();
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] key_code;
   logic [7:0] answer_lines;

   modport source (output valid, action, key_code, answer_lines, input ready);
   modport sink   (input valid, action, key_code, answer_lines, output ready);
endinterface

interface icl_rsp_if
   import icl_pkg::*;
();
   logic       valid;
   logic       ready;
   screen_type screen;
   logic [1:0] stars;
   logic [3:0] apartment;
   logic [1:0] dots;

   modport source (output valid, screen, stars, apartment, dots, input ready);
   modport sink   (input valid, screen, stars, apartment, dots, output ready);
endinterface

/* sv/intercom_code_lock_fsm.sv */
// Intercom door controller: keypad code lock and apartment ringing with answer timeout.
// Each accepted word (a key press or a one-second tick) yields exactly one result word
// describing the screen after that word. A word passes from the input register
// into the result register, and a new word is taken every cycle while the result is
// not stalled; the controller state updates as the word moves to the result
// register, which keeps consecutive words strictly ordered. A stalled result holds both
// stages. Configuration writes take effect on the next cycle.
module intercom_code_lock_fsm
   import icl_pkg::*;
#(
   parameter int NUM_APARTMENTS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   icl_req_if.sink                req_if,
   icl_rsp_if.source              rsp_if,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [8:0] APT_KEY_END = 9'({1'b0, KEY_1}) + 9'(NUM_APARTMENTS);

   // Configuration
   logic [11:0] access_code_ff;
   logic [7:0]  ring_ticks_ff;
   logic [7:0]  hold_ticks_ff;

   // Input stage
   logic       in_valid_ff, in_valid_in;
   logic       in_action_ff;
   logic [7:0] in_key_ff;
   logic [7:0] in_lines_ff;

   // Controller state
   logic [2:0] mode_ff, mode_in;
   logic [7:0] digits_ff, digits_in;
   logic [1:0] count_ff, count_in;
   logic [2:0] target_ff, target_in;
   logic [7:0] tick_ff, tick_in;

   // Result stage
   logic       out_valid_ff, out_valid_in;
   screen_type out_screen_ff, out_screen_in;
   logic [1:0] out_stars_ff, out_stars_in;
   logic [3:0] out_apt_ff, out_apt_in;
   logic [1:0] out_dots_ff, out_dots_in;

   logic       advance;
   logic       req_take;
   logic       rsp_take;
   logic [7:0] key_off;
   logic [7:0] digit_val;
   logic       key_is_digit;
   logic       key_is_apt;
   logic [7:0] tick_inc;
   logic [11:0] full_code;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_take  = req_if.valid && req_if.ready;
   assign rsp_take  = rsp_if.valid && rsp_if.ready;
   assign req_if.ready = !in_valid_ff || advance;

   assign key_off      = in_key_ff - KEY_1;
   assign digit_val    = in_key_ff - KEY_0;
   assign key_is_digit = (in_key_ff >= KEY_0) && (in_key_ff <= KEY_9);
   assign key_is_apt   = (in_key_ff >= KEY_1) && ({1'b0, in_key_ff} < APT_KEY_END)
                         && (in_key_ff <= KEY_8);
   assign tick_inc     = tick_ff + 8'd1;
   assign full_code    = {digits_ff, digit_val[3:0]};

   always_comb begin
      mode_in   = mode_ff;
      digits_in = digits_ff;
      count_in  = count_ff;
      target_in = target_ff;
      tick_in   = tick_ff;
      if (in_action_ff == ACTION_KEY) begin
         if (mode_ff == MODE_WELCOME) begin
            if (in_key_ff == KEY_C) begin
               mode_in   = MODE_ENTRY;
               count_in  = 2'd0;
               digits_in = 8'd0;
            end else if (key_is_apt) begin
               mode_in   = MODE_RING;
               target_in = key_off[2:0];
               tick_in   = 8'd0;
            end
         end else if (mode_ff == MODE_ENTRY) begin
            priority if (!key_is_digit) begin
               // A stray key on the last digit counts as a wrong code
               if (count_ff >= 2'd2) begin
                  mode_in = MODE_INVALID;
                  tick_in = 8'd0;
               end else begin
                  mode_in = MODE_WELCOME;
               end
               count_in = 2'd0;
            end else if (count_ff < 2'd2) begin
               digits_in = {digits_ff[3:0], digit_val[3:0]};
               count_in  = count_ff + 2'd1;
            end else begin
               count_in = 2'd0;
               tick_in  = 8'd0;
               mode_in  = (full_code == access_code_ff) ? MODE_OPENED : MODE_INVALID;
            end
         end
      end else begin
         if (mode_ff == MODE_RING) begin
            if (in_lines_ff[target_ff]) begin
               mode_in = MODE_OPENED;
               tick_in = 8'd0;
            end else if (tick_inc >= ring_ticks_ff || ring_ticks_ff == 8'd0) begin
               mode_in = MODE_WELCOME;
               tick_in = 8'd0;
            end else begin
               tick_in = tick_inc;
            end
         end else if (mode_ff == MODE_OPENED || mode_ff == MODE_INVALID) begin
            if (tick_inc >= hold_ticks_ff || hold_ticks_ff == 8'd0) begin
               mode_in = MODE_WELCOME;
               tick_in = 8'd0;
            end else begin
               tick_in = tick_inc;
            end
         end
      end
   end

   always_comb begin
      out_screen_in = mode_in;
      out_stars_in  = (mode_in == MODE_ENTRY) ? count_in : 2'd0;
      out_apt_in    = (mode_in == MODE_RING) ? ({1'b0, target_in} + 4'd1) : 4'd0;
      out_dots_in   = (mode_in == MODE_RING) ? tick_in[1:0] : 2'd0;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         access_code_ff <= ACCESS_CODE_RESET;
         ring_ticks_ff  <= RING_TICKS_RESET;
         hold_ticks_ff  <= HOLD_TICKS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACCESS_CODE: access_code_ff <= csr_wdata[11:0];
            CSR_RING_TICKS:  ring_ticks_ff  <= csr_wdata[7:0];
            CSR_HOLD_TICKS:  hold_ticks_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_WELCOME;
         digits_ff    <= 8'd0;
         count_ff     <= 2'd0;
         target_ff    <= 3'd0;
         tick_ff      <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mode_ff   <= mode_in;
            digits_ff <= digits_in;
            count_ff  <= count_in;
            target_ff <= target_in;
            tick_ff   <= tick_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_if.action;
         in_key_ff    <= req_if.key_code;
         in_lines_ff  <= req_if.answer_lines;
      end
      if (advance) begin
         out_screen_ff <= out_screen_in;
         out_stars_ff  <= out_stars_in;
         out_apt_ff    <= out_apt_in;
         out_dots_ff   <= out_dots_in;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.screen    = out_screen_ff;
   assign rsp_if.stars     = out_stars_ff;
   assign rsp_if.apartment = out_apt_ff;
   assign rsp_if.dots      = out_dots_ff;

`ifndef SYNTHESIS
   // Tick counter only runs while ringing or holding a message
   a_tick_idle: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_WELCOME || mode_ff == MODE_ENTRY) |-> tick_ff == 8'd0)
      else $error("tick count not cleared outside ring/hold");

   // Digit count belongs to code entry alone
   a_count_entry: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd0 |-> mode_ff == MODE_ENTRY)
      else $error("digit count set outside code entry");

   // A word waiting in the input register is never dropped
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input word lost while stalled");

   // Ringing results always name an apartment
   a_ring_apt: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_screen_ff == MODE_RING) |-> out_apt_ff != 4'd0)
      else $error("ringing result without apartment");
`endif

endmodule
